// ===== rtl/rfc_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte update for the record framer.
package rfc_pkg;

	localparam logic [15:0] CRC_INIT         = 16'hFFFF;
	localparam logic [15:0] CRC_POLY         = 16'hA001;
	localparam logic [15:0] HDR_CRC_BYTES    = 16'd10;
	localparam logic [15:0] MIN_FRAME_LENGTH = 16'd11;
	localparam logic [15:0] FRAME_LENGTH_RST = 16'd245;
	localparam logic [15:0] START_WORD_RST   = 16'hAA55;

	localparam logic OP_PAYLOAD = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;

	localparam logic REG_FRAME_LENGTH = 1'b0;
	localparam logic REG_START_WORD   = 1'b1;

	// byte positions within one queued command
	localparam logic [3:0] POS_SW_LO  = 4'd0;
	localparam logic [3:0] POS_SW_HI  = 4'd1;
	localparam logic [3:0] POS_FL_LO  = 4'd2;
	localparam logic [3:0] POS_FL_HI  = 4'd3;
	localparam logic [3:0] POS_CNT0   = 4'd4;
	localparam logic [3:0] POS_CNT1   = 4'd5;
	localparam logic [3:0] POS_CNT2   = 4'd6;
	localparam logic [3:0] POS_CNT3   = 4'd7;
	localparam logic [3:0] POS_DATA   = 4'd8;
	localparam logic [3:0] POS_CRC_LO = 4'd9;
	localparam logic [3:0] POS_CRC_HI = 4'd10;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic        hdr;
		logic        last;
		logic [7:0]  data;
		logic [15:0] start_word;
		logic [15:0] frame_length;
		logic [31:0] count;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/rfc_item_if.sv =====
// Input channel: one payload byte or counter clear per transaction.
interface rfc_item_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] payload_byte;

	modport source (output valid, output op, output payload_byte, input ready);
	modport sink (input valid, input op, input payload_byte, output ready);
endinterface

// ===== rtl/rfc_frame_if.sv =====
// Output channel: one frame byte per transaction with start and end marks.
interface rfc_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_start;
	logic       frame_end;

	modport source (output valid, output frame_byte, output frame_start, output frame_end,
		input ready);
	modport sink (input valid, input frame_byte, input frame_start, input frame_end,
		output ready);
endinterface

// ===== rtl/rfc_front.sv =====
// Front end: accepts items, tracks payload position and frame counter, builds commands.
module rfc_front (
	input  logic                   clk,
	input  logic                   arst_n,
	rfc_item_if.sink               item,
	input  logic [15:0]            frame_length,
	input  logic [15:0]            start_word,
	input  rfc_pkg::queue_status_t qstat,
	output logic                   push,
	output rfc_pkg::cmd_t          cmd
);

	logic [15:0] idx_q;
	logic [31:0] count_q;
	logic [15:0] payload_len;
	logic        last;
	logic        accept;

	assign payload_len = (frame_length > rfc_pkg::MIN_FRAME_LENGTH)
		? frame_length - rfc_pkg::HDR_CRC_BYTES : 16'd1;
	assign last   = ({1'b0, idx_q} + 17'd1) >= {1'b0, payload_len};
	assign item.ready = !qstat.full;
	assign accept = item.valid && item.ready;
	assign push   = accept && (item.op == rfc_pkg::OP_PAYLOAD);

	always_comb begin
		cmd.hdr          = (idx_q == 16'd0);
		cmd.last         = last;
		cmd.data         = item.payload_byte;
		cmd.start_word   = start_word;
		cmd.frame_length = frame_length;
		cmd.count        = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (item.op == rfc_pkg::OP_CLEAR) begin
				count_q <= '0;
			end else begin
				if (idx_q == 16'd0) begin
					count_q <= count_q + 32'd1;
				end
				idx_q <= last ? 16'd0 : idx_q + 16'd1;
			end
		end
	end

endmodule

// ===== rtl/rfc_fifo.sv =====
// Short command queue between front and back, head visible without a read cycle.
module rfc_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  rfc_pkg::cmd_t          cmd_in,
	input  logic                   pop,
	output rfc_pkg::cmd_t          head,
	output rfc_pkg::queue_status_t qstat
);

	rfc_pkg::cmd_t                     mem_q [rfc_pkg::QUEUE_DEPTH];
	logic [rfc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [rfc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [rfc_pkg::QUEUE_PTR_W:0]     cnt_q;

	assign head            = mem_q[rd_ptr_q];
	assign qstat.full      = (cnt_q == (rfc_pkg::QUEUE_PTR_W+1)'(rfc_pkg::QUEUE_DEPTH));
	assign qstat.not_empty = (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/rfc_back.sv =====
// Back end: walks each command byte by byte, keeps the running CRC, drives the output register.
module rfc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rfc_pkg::cmd_t          head,
	input  rfc_pkg::queue_status_t qstat,
	output logic                   pop,
	rfc_frame_if.source            frame
);

	logic [3:0]  pos_q;
	logic        started_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_start_q;
	logic        out_end_q;

	logic        adv;
	logic        emit;
	logic [3:0]  cur_pos;
	logic [3:0]  end_pos;
	logic        done;
	logic [7:0]  sel_byte;
	logic [15:0] crc_base;

	assign adv     = !out_valid_q || frame.ready;
	assign emit    = adv && qstat.not_empty;
	assign cur_pos = started_q ? pos_q : (head.hdr ? rfc_pkg::POS_SW_LO : rfc_pkg::POS_DATA);
	assign end_pos = head.last ? rfc_pkg::POS_CRC_HI : rfc_pkg::POS_DATA;
	assign done    = (cur_pos == end_pos);
	assign pop     = emit && done;
	// header restarts the CRC
	assign crc_base = (cur_pos == rfc_pkg::POS_SW_LO) ? rfc_pkg::CRC_INIT : crc_q;

	always_comb begin
		case (cur_pos)
			rfc_pkg::POS_SW_LO:  sel_byte = head.start_word[7:0];
			rfc_pkg::POS_SW_HI:  sel_byte = head.start_word[15:8];
			rfc_pkg::POS_FL_LO:  sel_byte = head.frame_length[7:0];
			rfc_pkg::POS_FL_HI:  sel_byte = head.frame_length[15:8];
			rfc_pkg::POS_CNT0:   sel_byte = head.count[7:0];
			rfc_pkg::POS_CNT1:   sel_byte = head.count[15:8];
			rfc_pkg::POS_CNT2:   sel_byte = head.count[23:16];
			rfc_pkg::POS_CNT3:   sel_byte = head.count[31:24];
			rfc_pkg::POS_CRC_LO: sel_byte = crc_q[7:0];
			rfc_pkg::POS_CRC_HI: sel_byte = crc_q[15:8];
			default:             sel_byte = head.data;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			started_q   <= 1'b0;
			crc_q       <= rfc_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
			if (emit) begin
				if (done) begin
					started_q <= 1'b0;
				end else begin
					started_q <= 1'b1;
					pos_q     <= cur_pos + 4'd1;
				end
				if (cur_pos <= rfc_pkg::POS_DATA) begin
					crc_q <= rfc_pkg::crc_byte(crc_base, sel_byte);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= sel_byte;
			out_start_q <= (cur_pos == rfc_pkg::POS_SW_LO);
			out_end_q   <= (cur_pos == rfc_pkg::POS_CRC_HI);
		end
	end

	assign frame.valid       = out_valid_q;
	assign frame.frame_byte  = out_byte_q;
	assign frame.frame_start = out_start_q;
	assign frame.frame_end   = out_end_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> (pos_q <= rfc_pkg::POS_CRC_HI))
		else $error("byte position beyond CRC");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.not_empty)
		else $error("pop from empty queue");
	a_start_end_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_start_q && out_end_q))
		else $error("frame start and end on the same byte");
	a_crc_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && cur_pos == rfc_pkg::POS_CRC_LO) |-> head.last)
		else $error("CRC emitted for a command that does not close the frame");

endmodule

// ===== rtl/record_framer_crc16.sv =====
// A result byte passes through the command queue and then the output register.
// Throughput: the back end (byte sequencer) sends one frame byte per cycle unless stalled;
// a mid-frame item yields one byte, a frame-opening item nine, a closing item two more.
// A four-entry command queue lets input acceptance run ahead of a stalled output.
// Reset (arst_n low, asynchronous): queue, counters and output valid clear; CRC to 0xFFFF;
// frame_length to 245 and start_word to 0xAA55.
module record_framer_crc16 (
	input  logic        clk,
	input  logic        arst_n,
	rfc_item_if.sink    item,
	rfc_frame_if.source frame,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0]            frame_length_q;
	logic [15:0]            start_word_q;
	logic                   push;
	logic                   pop;
	rfc_pkg::cmd_t          cmd;
	rfc_pkg::cmd_t          head;
	rfc_pkg::queue_status_t qstat;
	logic                   wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == rfc_pkg::REG_START_WORD)
		? {16'h0000, start_word_q} : {16'h0000, frame_length_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= rfc_pkg::FRAME_LENGTH_RST;
			start_word_q   <= rfc_pkg::START_WORD_RST;
		end else if (wr_en) begin
			if (paddr[2] == rfc_pkg::REG_FRAME_LENGTH) begin
				frame_length_q <= pwdata[15:0];
			end else begin
				start_word_q <= pwdata[15:0];
			end
		end
	end

	rfc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.frame_length (frame_length_q),
		.start_word   (start_word_q),
		.qstat        (qstat),
		.push         (push),
		.cmd          (cmd)
	);

	rfc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd_in (cmd),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	rfc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.frame  (frame)
	);

endmodule
